// ----- rtl/point_kinetics_euler_step_core_macros.svh -----
// Assertion macros shared by the point-kinetics Euler step core.
`ifndef POINT_KINETICS_EULER_STEP_CORE_MACROS_SVH
`define POINT_KINETICS_EULER_STEP_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Condition holds at every clock edge out of reset.
`define PKEC_ASSERT_HOLD(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("pkec assertion failed");
// Consequent holds in the same cycle as the antecedent.
`define PKEC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pkec assertion failed");
// Consequent holds in the cycle after the antecedent.
`define PKEC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pkec assertion failed");
`else
`define PKEC_ASSERT_HOLD(lbl, expr)
`define PKEC_ASSERT_IMPL(lbl, ante, cons)
`define PKEC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/pkec_pkg.sv -----
// Shared widths, constants and interface types of the point-kinetics Euler step core.
package pkec_pkg;

	localparam int GROUPS_DEF = 6;

	localparam int VAL_W  = 48;   // Q20.28 state values
	localparam int COEF_W = 32;   // Q0.32 coefficients, multiplier operand width
	localparam int K_W    = 29;   // dt/Lambda register width
	localparam int MAG_W  = 35;   // magnitude of 4*rho - beta
	localparam int PROD_W = 2 * COEF_W;
	localparam int ACC_W  = 112;  // holds a 64 x 48 bit product
	localparam int SUM_W  = 52;   // positive sum of the density update
	localparam int DVD_W  = 80;   // power times build coefficient
	localparam int QUO_W  = 49;   // quotient bits kept before the cap

	// Largest stored value, 1e6 in Q20.28.
	localparam logic [VAL_W-1:0] CAP = 48'd268435456000000;

	// Weight of a partial product in the accumulator.
	localparam logic [1:0] SH_0  = 2'd0;
	localparam logic [1:0] SH_32 = 2'd1;
	localparam logic [1:0] SH_64 = 2'd2;

	typedef struct packed {
		logic              issue;
		logic              clear;
		logic [1:0]        shift;
		logic [COEF_W-1:0] a;
		logic [COEF_W-1:0] b;
	} mac_op_t;

	typedef struct packed {
		logic              start;
		logic [DVD_W-1:0]  dividend;
		logic [COEF_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ----- rtl/pkec_mac.sv -----
// Shared 32 x 32 multiplier with a registered product and a shifting accumulator.
module pkec_mac (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pkec_pkg::mac_op_t         op,
	output logic [pkec_pkg::ACC_W-1:0] acc
);

	logic                        valid_s1;
	logic                        clear_s1;
	logic [1:0]                  shift_s1;
	logic [pkec_pkg::PROD_W-1:0] prod_s1;
	logic [pkec_pkg::ACC_W-1:0]  addend;
	logic [pkec_pkg::ACC_W-1:0]  acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= op.issue;
		end
	end

	always_ff @(posedge clk) begin
		if (op.issue) begin
			prod_s1  <= pkec_pkg::PROD_W'(op.a) * pkec_pkg::PROD_W'(op.b);
			clear_s1 <= op.clear;
			shift_s1 <= op.shift;
		end
	end

	// Place the product at its weight.
	always_comb begin
		unique case (shift_s1)
			pkec_pkg::SH_0:  addend = pkec_pkg::ACC_W'(prod_s1);
			pkec_pkg::SH_32: addend = pkec_pkg::ACC_W'(prod_s1) << pkec_pkg::COEF_W;
			pkec_pkg::SH_64: addend = pkec_pkg::ACC_W'(prod_s1) << (2 * pkec_pkg::COEF_W);
			default:         addend = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			acc_q <= (clear_s1 ? '0 : acc_q) + addend;
		end
	end

	assign acc = acc_q;

endmodule

// ----- rtl/pkec_div.sv -----
// Restoring divider, one quotient bit a cycle, with the result capped at 1e6.
module pkec_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pkec_pkg::div_req_t         req,
	output pkec_pkg::div_stat_t        stat,
	output logic [pkec_pkg::VAL_W-1:0] quotient
);

	localparam int CW = $clog2(pkec_pkg::QUO_W + 1);

	logic                        busy_q;
	logic                        done_q;
	logic [CW-1:0]               cnt_q;
	logic [pkec_pkg::COEF_W-1:0] dvs_q;
	logic [pkec_pkg::COEF_W-1:0] rem_q;
	logic [pkec_pkg::QUO_W-1:0]  dvd_q;
	logic [pkec_pkg::QUO_W-1:0]  quo_q;
	logic [pkec_pkg::VAL_W-1:0]  res_q;
	logic                        sat;
	logic [pkec_pkg::COEF_W:0]   trial;
	logic [pkec_pkg::COEF_W:0]   diff;
	logic                        take;

	// A zero divisor, or a quotient that cannot fit the kept bits, saturates.
	assign sat = (req.divisor == '0) ||
		(pkec_pkg::COEF_W'(req.dividend[pkec_pkg::DVD_W-1:pkec_pkg::QUO_W]) >= req.divisor);

	assign trial = {rem_q, dvd_q[pkec_pkg::QUO_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign take  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= sat ? '0 : CW'(pkec_pkg::QUO_W);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvs_q <= req.divisor;
			rem_q <= pkec_pkg::COEF_W'(req.dividend[pkec_pkg::DVD_W-1:pkec_pkg::QUO_W]);
			dvd_q <= req.dividend[pkec_pkg::QUO_W-1:0];
			quo_q <= sat ? '1 : '0;
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				rem_q <= take ? diff[pkec_pkg::COEF_W-1:0] : trial[pkec_pkg::COEF_W-1:0];
				dvd_q <= dvd_q << 1;
				quo_q <= {quo_q[pkec_pkg::QUO_W-2:0], take};
			end else begin
				res_q <= (quo_q > pkec_pkg::QUO_W'(pkec_pkg::CAP)) ?
					pkec_pkg::CAP : quo_q[pkec_pkg::VAL_W-1:0];
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = res_q;

endmodule

// ----- rtl/point_kinetics_euler_step_core.sv -----
// Top level of the point-kinetics Euler step core: sequencer, state store and ports.
//
//  Channel  Direction  Handshake           Payload
//  s_*      in         s_tvalid/s_tready   tdata: reactivity, initial_power; tuser: cmd
//  m_*      out        m_tvalid/m_tready   tdata: state_value; tuser: status, element_index
//  cfg_*    in         cfg_we              cfg_index selects the register, cfg_data the value
//
// A step request runs each of its terms on the shared 32 x 32 multiplier, which does
// two to four partial products per term. An init request also runs the one-bit-a-cycle
// divider for each group; a group whose quotient saturates skips the bit steps. Results
// then leave one a cycle while the output is not stalled. Reset clears the state store,
// the configuration and the control registers at once; no clearing pass is needed.
// A stalled output holds the sequencer in its emit state; no new request is taken until
// the last result of the current one sits in the output register.
`include "point_kinetics_euler_step_core_macros.svh"

module point_kinetics_euler_step_core #(
	parameter int GROUPS = pkec_pkg::GROUPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Request stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // [31:0] reactivity, [79:32] initial_power
	input  logic        s_tuser,   // [0] cmd
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [47:0] state_value
	output logic [3:0]  m_tuser,   // [0] status, [3:1] element_index
	output logic        m_tlast,
	// Configuration writes.
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	localparam int GIW = (GROUPS > 1) ? $clog2(GROUPS) : 1;

	// Sequencer states.
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_TERM_P = 4'd1;
	localparam logic [3:0] S_TERM_N = 4'd2;
	localparam logic [3:0] S_DCY    = 4'd3;
	localparam logic [3:0] S_BLD    = 4'd4;
	localparam logic [3:0] S_NUPD   = 4'd5;
	localparam logic [3:0] S_EQ_MUL = 4'd6;
	localparam logic [3:0] S_EQ_DIV = 4'd7;
	localparam logic [3:0] S_EMIT   = 4'd8;
	localparam logic [3:0] S_REJ    = 4'd9;

	// Phase at which the accumulator result is ready.
	localparam logic [2:0] PH_DONE2 = 3'd3;
	localparam logic [2:0] PH_DONE4 = 3'd5;

	localparam logic CMD_INIT  = 1'b1;
	localparam logic ST_OK     = 1'b0;
	localparam logic ST_REJECT = 1'b1;

	localparam logic [2:0] REG_K        = 3'd0;
	localparam logic [2:0] REG_BETA     = 3'd1;
	localparam logic [2:0] REG_BUILD_12 = 3'd2;
	localparam logic [2:0] REG_BUILD_34 = 3'd3;
	localparam logic [2:0] REG_BUILD_56 = 3'd4;
	localparam logic [2:0] REG_DECAY_12 = 3'd5;
	localparam logic [2:0] REG_DECAY_34 = 3'd6;
	localparam logic [2:0] REG_DECAY_56 = 3'd7;

	typedef logic [2:0][63:0] coef_bank_t;

	// Coefficient of group g: two groups to a register, the lower in the low half.
	function automatic logic [pkec_pkg::COEF_W-1:0] coef_sel(input coef_bank_t bank,
		input logic [2:0] g);
		logic [63:0] r;
		case (g[2:1])
			2'd1:    r = bank[1];
			2'd2:    r = bank[2];
			default: r = bank[0];
		endcase
		coef_sel = g[0] ? r[63:32] : r[31:0];
	endfunction

	// Difference of the positive and negative parts, held to 0..1e6.
	function automatic logic [pkec_pkg::VAL_W-1:0] settle(input logic [pkec_pkg::SUM_W-1:0] pos,
		input logic [pkec_pkg::VAL_W-1:0] neg);
		logic [pkec_pkg::SUM_W-1:0] d;
		d = pos - pkec_pkg::SUM_W'(neg);
		if (pkec_pkg::SUM_W'(neg) >= pos)
			settle = '0;
		else if (d > pkec_pkg::SUM_W'(pkec_pkg::CAP))
			settle = pkec_pkg::CAP;
		else
			settle = d[pkec_pkg::VAL_W-1:0];
	endfunction

	// Configuration registers.
	logic [pkec_pkg::K_W-1:0]    k_q;
	logic [pkec_pkg::COEF_W-1:0] beta_q;
	coef_bank_t                  build_q;
	coef_bank_t                  decay_q;

	// Sequencer.
	logic [3:0] state_q;
	logic [2:0] ph_q;
	logic [2:0] idx_q;

	// Working registers.
	logic [pkec_pkg::MAG_W-1:0]  mag_q;
	logic                        neg_q;
	logic [pkec_pkg::VAL_W-1:0]  p_q;
	logic [pkec_pkg::PROD_W-1:0] prodk_q;
	logic [pkec_pkg::SUM_W-1:0]  npos_q;
	logic [pkec_pkg::VAL_W-1:0]  nneg_q;
	logic [pkec_pkg::VAL_W-1:0]  dcy_q;

	// Reactor state.
	logic [pkec_pkg::VAL_W-1:0] n_q;
	logic [pkec_pkg::VAL_W-1:0] c_q [GROUPS];

	// Output register.
	logic                       m_tvalid_q;
	logic [pkec_pkg::VAL_W-1:0] out_value_q;
	logic [2:0]                 out_idx_q;
	logic                       out_status_q;
	logic                       out_last_q;

	// Datapath signals.
	logic                        acc_in;
	logic                        out_free;
	logic                        out_load;
	logic                        last_grp;
	logic                        two_op;
	logic [31:0]                 rho;
	logic [31:0]                 abs_rho;
	logic [pkec_pkg::MAG_W-1:0]  r4;
	logic [pkec_pkg::MAG_W-1:0]  beta_x;
	logic [pkec_pkg::MAG_W-1:0]  mag_d;
	logic                        neg_d;
	logic [pkec_pkg::VAL_W-1:0]  power;
	logic [2:0]                  rd_idx;
	logic [pkec_pkg::VAL_W-1:0]  cur_c;
	logic [pkec_pkg::COEF_W-1:0] bcoef;
	logic [pkec_pkg::COEF_W-1:0] dcoef;
	logic [pkec_pkg::COEF_W-1:0] mac_a;
	logic [pkec_pkg::VAL_W-1:0]  mac_x;
	pkec_pkg::mac_op_t           mac_op;
	logic [pkec_pkg::ACC_W-1:0]  acc;
	logic [pkec_pkg::VAL_W-1:0]  mac_q32;
	logic [pkec_pkg::VAL_W-1:0]  term;
	pkec_pkg::div_req_t          div_req;
	pkec_pkg::div_stat_t         div_stat;
	logic [pkec_pkg::VAL_W-1:0]  div_quo;
	logic                        c_we;
	logic [pkec_pkg::VAL_W-1:0]  c_wdata;
	logic                        n_we;
	logic [pkec_pkg::VAL_W-1:0]  n_wdata;

	assign s_tready = (state_q == S_IDLE);
	assign acc_in   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = ((state_q == S_EMIT) || (state_q == S_REJ)) && out_free;
	assign last_grp = (idx_q == 3'(GROUPS - 1));

	// Split 4*rho - beta into magnitude and sign. rho is Q1.30 and beta Q0.32, so
	// rho is shifted left by two to bring both to the same scale.
	assign rho     = s_tdata[31:0];
	assign power   = s_tdata[79:32];
	assign abs_rho = rho[31] ? (32'd0 - rho) : rho;
	assign r4      = pkec_pkg::MAG_W'({abs_rho, 2'b00});
	assign beta_x  = pkec_pkg::MAG_W'(beta_q);

	always_comb begin
		if (rho[31]) begin
			mag_d = r4 + beta_x;
			neg_d = 1'b1;
		end else if (r4 >= beta_x) begin
			mag_d = r4 - beta_x;
			neg_d = 1'b0;
		end else begin
			mag_d = beta_x - r4;
			neg_d = 1'b1;
		end
	end

	// One read port on the concentration store: the current group while computing,
	// element minus one while emitting.
	assign rd_idx = (state_q == S_EMIT) ? 3'(idx_q - 3'd1) : idx_q;
	assign cur_c  = c_q[rd_idx[GIW-1:0]];
	assign bcoef  = coef_sel(build_q, idx_q);
	assign dcoef  = coef_sel(decay_q, idx_q);

	// Multiplier operands. Most terms are a 32-bit coefficient times a 48-bit value,
	// done as a low and a high partial product.
	always_comb begin
		mac_a = '0;
		mac_x = '0;
		case (state_q)
			S_TERM_P: begin
				mac_a = pkec_pkg::COEF_W'(k_q);
				mac_x = pkec_pkg::VAL_W'(mag_q);
			end
			S_DCY: begin
				mac_a = dcoef;
				mac_x = cur_c;
			end
			S_BLD: begin
				mac_a = bcoef;
				mac_x = n_q;
			end
			S_EQ_MUL: begin
				mac_a = bcoef;
				mac_x = p_q;
			end
			default: begin
				mac_a = '0;
				mac_x = '0;
			end
		endcase
	end

	assign two_op = (state_q == S_TERM_P) || (state_q == S_DCY) ||
		(state_q == S_BLD) || (state_q == S_EQ_MUL);

	always_comb begin
		mac_op       = '0;
		mac_op.clear = (ph_q == 3'd0);
		if (two_op && (ph_q < 3'd2)) begin
			mac_op.issue = 1'b1;
			mac_op.a     = mac_a;
			mac_op.b     = (ph_q == 3'd0) ? mac_x[31:0] : pkec_pkg::COEF_W'(mac_x[47:32]);
			mac_op.shift = (ph_q == 3'd0) ? pkec_pkg::SH_0 : pkec_pkg::SH_32;
		end else if ((state_q == S_TERM_N) && (ph_q < 3'd4)) begin
			// The 64-bit product k*mag times the 48-bit density, four partial products.
			mac_op.issue = 1'b1;
			case (ph_q[1:0])
				2'd0: begin
					mac_op.a     = prodk_q[31:0];
					mac_op.b     = n_q[31:0];
					mac_op.shift = pkec_pkg::SH_0;
				end
				2'd1: begin
					mac_op.a     = prodk_q[31:0];
					mac_op.b     = pkec_pkg::COEF_W'(n_q[47:32]);
					mac_op.shift = pkec_pkg::SH_32;
				end
				2'd2: begin
					mac_op.a     = prodk_q[63:32];
					mac_op.b     = n_q[31:0];
					mac_op.shift = pkec_pkg::SH_32;
				end
				default: begin
					mac_op.a     = prodk_q[63:32];
					mac_op.b     = pkec_pkg::COEF_W'(n_q[47:32]);
					mac_op.shift = pkec_pkg::SH_64;
				end
			endcase
		end else begin
			mac_op.clear = 1'b0;
		end
	end

	pkec_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (mac_op),
		.acc    (acc)
	);

	// Coefficient times value, truncated back to Q20.28.
	assign mac_q32 = acc[pkec_pkg::COEF_W +: pkec_pkg::VAL_W];
	// Feedback term: (k*mag*n) >> 64.
	assign term    = acc[2 * pkec_pkg::COEF_W +: pkec_pkg::VAL_W];

	assign div_req.start    = (state_q == S_EQ_MUL) && (ph_q == PH_DONE2);
	assign div_req.dividend = acc[pkec_pkg::DVD_W-1:0];
	assign div_req.divisor  = dcoef;

	pkec_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ph_q    <= '0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					ph_q  <= '0;
					idx_q <= '0;
					if (acc_in) begin
						if (s_tuser == CMD_INIT)
							state_q <= (power == '0) ? S_REJ : S_EQ_MUL;
						else
							state_q <= S_TERM_P;
					end
				end
				S_TERM_P: begin
					ph_q <= ph_q + 3'd1;
					if (ph_q == PH_DONE2) begin
						ph_q    <= '0;
						state_q <= S_TERM_N;
					end
				end
				S_TERM_N: begin
					ph_q <= ph_q + 3'd1;
					if (ph_q == PH_DONE4) begin
						ph_q    <= '0;
						idx_q   <= '0;
						state_q <= S_DCY;
					end
				end
				S_DCY: begin
					ph_q <= ph_q + 3'd1;
					if (ph_q == PH_DONE2) begin
						ph_q    <= '0;
						state_q <= S_BLD;
					end
				end
				S_BLD: begin
					ph_q <= ph_q + 3'd1;
					if (ph_q == PH_DONE2) begin
						ph_q <= '0;
						if (last_grp) begin
							state_q <= S_NUPD;
						end else begin
							idx_q   <= idx_q + 3'd1;
							state_q <= S_DCY;
						end
					end
				end
				S_NUPD: begin
					idx_q   <= '0;
					state_q <= S_EMIT;
				end
				S_EQ_MUL: begin
					ph_q <= ph_q + 3'd1;
					if (ph_q == PH_DONE2) begin
						ph_q    <= '0;
						state_q <= S_EQ_DIV;
					end
				end
				S_EQ_DIV: begin
					if (div_stat.done) begin
						if (last_grp) begin
							idx_q   <= '0;
							state_q <= S_EMIT;
						end else begin
							idx_q   <= idx_q + 3'd1;
							state_q <= S_EQ_MUL;
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						if (idx_q == 3'(GROUPS))
							state_q <= S_IDLE;
						else
							idx_q <= idx_q + 3'd1;
					end
				end
				S_REJ: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Working registers of the step and init sequences.
	always_ff @(posedge clk) begin
		if (acc_in) begin
			mag_q <= mag_d;
			neg_q <= neg_d;
			p_q   <= (power > pkec_pkg::CAP) ? pkec_pkg::CAP : power;
		end
		if ((state_q == S_TERM_P) && (ph_q == PH_DONE2))
			prodk_q <= acc[pkec_pkg::PROD_W-1:0];
		if ((state_q == S_TERM_N) && (ph_q == PH_DONE4)) begin
			npos_q <= pkec_pkg::SUM_W'(n_q) + (neg_q ? '0 : pkec_pkg::SUM_W'(term));
			nneg_q <= neg_q ? term : '0;
		end
		if ((state_q == S_DCY) && (ph_q == PH_DONE2)) begin
			dcy_q  <= mac_q32;
			npos_q <= npos_q + pkec_pkg::SUM_W'(mac_q32);
		end
	end

	// State store writes. In a step, a group's concentration is replaced once its decay
	// product has gone into the density sum; the density is replaced last.
	assign c_we    = ((state_q == S_BLD) && (ph_q == PH_DONE2)) ||
		((state_q == S_EQ_DIV) && div_stat.done);
	assign c_wdata = (state_q == S_BLD) ?
		settle(pkec_pkg::SUM_W'(cur_c) + pkec_pkg::SUM_W'(mac_q32), dcy_q) : div_quo;
	assign n_we    = (state_q == S_NUPD) || ((state_q == S_EQ_DIV) && div_stat.done && last_grp);
	assign n_wdata = (state_q == S_NUPD) ? settle(npos_q, nneg_q) : p_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
			for (int i = 0; i < GROUPS; i++)
				c_q[i] <= '0;
		end else begin
			if (n_we)
				n_q <= n_wdata;
			if (c_we)
				c_q[idx_q[GIW-1:0]] <= c_wdata;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= '0;
			beta_q  <= '0;
			build_q <= '0;
			decay_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_K:        k_q        <= cfg_data[pkec_pkg::K_W-1:0];
				REG_BETA:     beta_q     <= cfg_data[pkec_pkg::COEF_W-1:0];
				REG_BUILD_12: build_q[0] <= cfg_data;
				REG_BUILD_34: build_q[1] <= cfg_data;
				REG_BUILD_56: build_q[2] <= cfg_data;
				REG_DECAY_12: decay_q[0] <= cfg_data;
				REG_DECAY_34: decay_q[1] <= cfg_data;
				REG_DECAY_56: decay_q[2] <= cfg_data;
				default:      k_q        <= k_q;
			endcase
		end
	end

	// Output register: element 0 is the density, the rest the precursor groups.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (state_q == S_REJ) begin
				out_value_q  <= '0;
				out_idx_q    <= '0;
				out_status_q <= ST_REJECT;
				out_last_q   <= 1'b1;
			end else begin
				out_value_q  <= (idx_q == 3'd0) ? n_q : cur_c;
				out_idx_q    <= idx_q;
				out_status_q <= ST_OK;
				out_last_q   <= (idx_q == 3'(GROUPS));
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_value_q;
	assign m_tuser  = {out_idx_q, out_status_q};
	assign m_tlast  = out_last_q;

	`PKEC_ASSERT_IMPL(a_div_only_in_init, div_stat.busy, state_q == S_EQ_DIV)
	`PKEC_ASSERT_HOLD(a_density_capped, n_q <= pkec_pkg::CAP)
	`PKEC_ASSERT_NEXT(a_accept_blocks_next, acc_in, !s_tready)
	`PKEC_ASSERT_IMPL(a_last_is_top_element, m_tvalid_q && out_last_q && (out_status_q == ST_OK),
		out_idx_q == 3'(GROUPS))

endmodule
